>>> rtl/wrsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrsi_pkg
// Shared widths, constants and state encodings for the Wilder RSI stream.
// ----------------------------------------------------------------------------
package wrsi_pkg;

    localparam int PRICE_BITS_DEF = 32;   // default price width inside the block
    localparam int FRAC_BITS_DEF  = 16;   // default fraction bits of the averages
    localparam int PRICE_W        = 32;   // price field width on the stream
    localparam int PERIOD_W       = 8;
    localparam int COUNT_W        = 9;
    localparam int RSI_W          = 14;
    localparam int OUT_DATA_W     = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
    localparam logic [RSI_W-1:0]    RSI_FULL     = 14'd10000;
    localparam logic [RSI_W-1:0]    RSI_MID      = 14'd5000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_UPD,
        ST_PSTART,
        ST_PDIV,
        ST_RCHK,
        ST_RATIO,
        ST_DONE
    } top_state_t;

    typedef enum logic [1:0] {
        RT_IDLE,
        RT_MUL,
        RT_DIV
    } ratio_state_t;

endpackage
`default_nettype wire

>>> rtl/wrsi_pdiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrsi_pdiv
// Bit-serial restoring divider by the 8-bit period: one quotient bit per
// cycle, narrow remainder, low QW quotient bits kept.
// ----------------------------------------------------------------------------
module wrsi_pdiv #(
    parameter int DW = wrsi_pkg::PRICE_BITS_DEF + 2 * wrsi_pkg::FRAC_BITS_DEF,
    parameter int QW = wrsi_pkg::PRICE_BITS_DEF + wrsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [DW-1:0]                 dividend,
    input  wire logic [wrsi_pkg::PERIOD_W-1:0] divisor,
    output logic      [QW-1:0]                 quotient,
    output logic                               rem_nz,
    output logic                               done
);
    import wrsi_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]       num_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [PERIOD_W-1:0] rem_next;
    logic [QW-1:0]       quo_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [PERIOD_W:0]   trial;
    logic                ge;

    always_comb
    begin
        trial = {rem_reg, num_reg[DW-1]};
        ge    = (trial >= {1'b0, divisor});
        if (ge)
        begin
            rem_next = PERIOD_W'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_next = trial[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DW-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign rem_nz   = |rem_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

>>> rtl/wrsi_ratio.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrsi_ratio
// floor(10000*gain/(gain+loss)): shift-add by the constant, then a
// restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrsi_ratio #(
    parameter int AW = wrsi_pkg::PRICE_BITS_DEF + wrsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [AW-1:0]              gain,
    input  wire logic [AW-1:0]              loss,
    output logic      [wrsi_pkg::RSI_W-1:0] rsi,
    output logic                            done
);
    import wrsi_pkg::*;

    localparam int NW = AW + RSI_W;
    localparam int CW = $clog2(NW + 1);

    ratio_state_t     state_reg;
    ratio_state_t     state_next;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic [NW-1:0]    acc_reg;
    logic [NW-1:0]    add_reg;
    logic [RSI_W-1:0] k_reg;
    logic [AW:0]      den_reg;
    logic [AW:0]      rem_reg;
    logic [AW:0]      rem_next;
    logic [RSI_W-1:0] quo_reg;
    logic [AW+1:0]    trial;
    logic             ge;
    logic             mul_last;
    logic             div_last;

    always_comb
    begin
        mul_last   = (cnt_reg == CW'(RSI_W - 1));
        div_last   = (cnt_reg == CW'(NW - 1));
        state_next = state_reg;
        case (state_reg)
            RT_IDLE:
            begin
                if (start)
                begin
                    state_next = RT_MUL;
                end
            end
            RT_MUL:
            begin
                if (mul_last)
                begin
                    state_next = RT_DIV;
                end
            end
            RT_DIV:
            begin
                if (div_last)
                begin
                    state_next = RT_IDLE;
                end
            end
            default:
            begin
                state_next = RT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        trial = {rem_reg, acc_reg[NW-1]};
        ge    = (trial >= {1'b0, den_reg});
        if (ge)
        begin
            rem_next = (AW + 1)'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = trial[AW:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RT_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == RT_DIV) && div_last;
            if (state_reg == state_next && state_reg != RT_IDLE)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            RT_IDLE:
            begin
                if (start)
                begin
                    acc_reg <= '0;
                    add_reg <= NW'(gain);
                    k_reg   <= RSI_FULL;
                    den_reg <= (AW + 1)'(gain) + (AW + 1)'(loss);
                    rem_reg <= '0;
                end
            end
            RT_MUL:
            begin
                if (k_reg[0])
                begin
                    acc_reg <= acc_reg + add_reg;
                end
                add_reg <= {add_reg[NW-2:0], 1'b0};
                k_reg   <= {1'b0, k_reg[RSI_W-1:1]};
            end
            RT_DIV:
            begin
                acc_reg <= {acc_reg[NW-2:0], 1'b0};
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[RSI_W-2:0], ge};
            end
            default:
            begin
            end
        endcase
    end

    assign rsi  = quo_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

>>> rtl/wilder_rsi_stream.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wilder_rsi_stream
// Wilder relative strength index over a stream of prices, one result a beat.
// ----------------------------------------------------------------------------
// One price beat in gives one RSI beat out, in hundredths (0..10000), with
// tuser[0] set once a full period of changes has been averaged; before that
// the value is 5000. tlast on the input ends a series: its result is sent as
// usual and the history is cleared. Items are processed one at a time. A
// warm-up item skips the dividers. In a seeding or smoothing item, the period
// divider yields one quotient bit per cycle over the PRICE_BITS+2*FRAC_BITS
// dividend bits, then the ratio unit runs its shift-add multiply and its
// division; the ratio part is skipped when the average loss is zero. A
// finished result waits in the output register while the next beat is
// taken. cfg_we writes the lookback period (reset 14, 0 acts as 1); write it
// only while the block is idle.
// ----------------------------------------------------------------------------
module wilder_rsi_stream #(
    parameter int PRICE_BITS = wrsi_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = wrsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [wrsi_pkg::PERIOD_W-1:0]   cfg_wdata,   // lookback period
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [wrsi_pkg::PRICE_W-1:0]    s_tdata,     // [31:0] price
    input  wire logic                            s_tlast,     // last_sample
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [wrsi_pkg::OUT_DATA_W-1:0] m_tdata,     // [13:0] rsi_value, rest 0
    output logic      [0:0]                      m_tuser      // [0] rsi_ready
);
    import wrsi_pkg::*;

    localparam int AW = PRICE_BITS + FRAC_BITS;
    localparam int DW = AW + FRAC_BITS;

    top_state_t          state_reg;
    top_state_t          state_next;
    logic                pdiv_start;
    logic                rat_start;
    logic                out_load;

    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] p_eff;
    logic [PRICE_BITS-1:0] price_reg;
    logic                last_reg;
    logic [PRICE_BITS-1:0] prev_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [PRICE_BITS-1:0] gain_reg;
    logic [PRICE_BITS-1:0] loss_reg;
    logic [AW-1:0]       avg_g_reg;
    logic [AW-1:0]       avg_l_reg;
    logic [AW-1:0]       diff_g_reg;
    logic [AW-1:0]       diff_l_reg;
    logic                up_g_reg;
    logic                up_l_reg;
    logic                seed_reg;
    logic [RSI_W-1:0]    value_reg;
    logic                ready_reg;

    logic                out_valid_reg;
    logic [RSI_W-1:0]    out_rsi_reg;
    logic                out_rdy_reg;

    logic                cnt_zero;
    logic                cnt_le;
    logic                cnt_eq;
    logic [AW-1:0]       x_g;
    logic [AW-1:0]       x_l;
    logic [DW-1:0]       div_in_g;
    logic [DW-1:0]       div_in_l;
    logic [AW-1:0]       q_g;
    logic [AW-1:0]       q_l;
    logic                rnz_g;
    logic                rnz_l;
    logic                pdiv_done_g;
    logic                pdiv_done_l;
    logic [RSI_W-1:0]    rat_rsi;
    logic                rat_done;

    assign p_eff    = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign cnt_zero = (count_reg == '0);
    assign cnt_le   = (count_reg <= {1'b0, p_eff});
    assign cnt_eq   = (count_reg == {1'b0, p_eff});
    assign x_g      = AW'(gain_reg) << FRAC_BITS;
    assign x_l      = AW'(loss_reg) << FRAC_BITS;
    assign div_in_g = seed_reg ? {avg_g_reg, {FRAC_BITS{1'b0}}} : DW'(diff_g_reg);
    assign div_in_l = seed_reg ? {avg_l_reg, {FRAC_BITS{1'b0}}} : DW'(diff_l_reg);

    wrsi_pdiv #(
        .DW (DW),
        .QW (AW)
    ) u_pdiv_g (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pdiv_start),
        .dividend (div_in_g),
        .divisor  (p_eff),
        .quotient (q_g),
        .rem_nz   (rnz_g),
        .done     (pdiv_done_g)
    );

    wrsi_pdiv #(
        .DW (DW),
        .QW (AW)
    ) u_pdiv_l (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pdiv_start),
        .dividend (div_in_l),
        .divisor  (p_eff),
        .quotient (q_l),
        .rem_nz   (rnz_l),
        .done     (pdiv_done_l)
    );

    wrsi_ratio #(
        .AW (AW)
    ) u_ratio (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rat_start),
        .gain  (avg_g_reg),
        .loss  (avg_l_reg),
        .rsi   (rat_rsi),
        .done  (rat_done)
    );

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        pdiv_start = 1'b0;
        rat_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (cnt_zero || (cnt_le && !cnt_eq))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_PSTART;
                end
            end
            ST_PSTART:
            begin
                pdiv_start = 1'b1;
                state_next = ST_PDIV;
            end
            ST_PDIV:
            begin
                if (pdiv_done_g)
                begin
                    state_next = ST_RCHK;
                end
            end
            ST_RCHK:
            begin
                if (avg_l_reg != '0)
                begin
                    rat_start  = 1'b1;
                    state_next = ST_RATIO;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RATIO:
            begin
                if (rat_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            period_reg    <= PERIOD_RESET;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            count_reg     <= '0;
            avg_g_reg     <= '0;
            avg_l_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == ST_UPD && !cnt_zero && cnt_le)
            begin
                // warm-up: running sums of the raw changes
                avg_g_reg <= avg_g_reg + AW'(gain_reg);
                avg_l_reg <= avg_l_reg + AW'(loss_reg);
            end
            else if (state_reg == ST_PDIV && pdiv_done_g)
            begin
                if (seed_reg)
                begin
                    avg_g_reg <= q_g;
                    avg_l_reg <= q_l;
                end
                else
                begin
                    // falling averages round the step up so the result floors
                    avg_g_reg <= up_g_reg ? avg_g_reg + q_g : avg_g_reg - q_g - AW'(rnz_g);
                    avg_l_reg <= up_l_reg ? avg_l_reg + q_l : avg_l_reg - q_l - AW'(rnz_l);
                end
            end
            else if (out_load && last_reg)
            begin
                avg_g_reg <= '0;
                avg_l_reg <= '0;
            end

            if (out_load)
            begin
                if (last_reg)
                begin
                    prev_reg  <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    prev_reg <= price_reg;
                    if (cnt_le)
                    begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    price_reg <= PRICE_BITS'(s_tdata);
                    last_reg  <= s_tlast;
                end
            end
            ST_CALC:
            begin
                value_reg <= RSI_MID;
                ready_reg <= 1'b0;
                if (price_reg > prev_reg)
                begin
                    gain_reg <= price_reg - prev_reg;
                    loss_reg <= '0;
                end
                else
                begin
                    gain_reg <= '0;
                    loss_reg <= prev_reg - price_reg;
                end
            end
            ST_UPD:
            begin
                seed_reg <= cnt_le;
                if (!cnt_zero && (cnt_eq || !cnt_le))
                begin
                    ready_reg <= 1'b1;
                end
                up_g_reg   <= (x_g >= avg_g_reg);
                up_l_reg   <= (x_l >= avg_l_reg);
                diff_g_reg <= (x_g >= avg_g_reg) ? x_g - avg_g_reg : avg_g_reg - x_g;
                diff_l_reg <= (x_l >= avg_l_reg) ? x_l - avg_l_reg : avg_l_reg - x_l;
            end
            ST_RCHK:
            begin
                if (avg_l_reg == '0)
                begin
                    value_reg <= (avg_g_reg != '0) ? RSI_FULL : RSI_MID;
                end
            end
            ST_RATIO:
            begin
                if (rat_done)
                begin
                    value_reg <= rat_rsi;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_rsi_reg <= value_reg;
                    out_rdy_reg <= ready_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_rsi_reg);
    assign m_tuser  = out_rdy_reg;

`ifndef SYNTH
    a_not_ready_mid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[RSI_W-1:0] == RSI_MID)
        else $error("result without ready flag is not the midpoint");

    a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[RSI_W-1:0] <= RSI_FULL)
        else $error("rsi value above full scale");

    a_pdiv_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        pdiv_done_g == pdiv_done_l)
        else $error("gain and loss dividers out of step");

    a_ratio_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        rat_done |-> state_reg == ST_RATIO)
        else $error("ratio unit finished outside the ratio wait");

    a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_CALC)
        else $error("accepted beat did not start a calculation");
`endif

endmodule
`default_nettype wire
